### rtl/sts_pkg.sv
package sts_pkg;

    // dense token codes
    localparam logic [5:0] TK_END       = 6'd0;
    localparam logic [5:0] TK_ERROR     = 6'd1;
    localparam logic [5:0] TK_LF        = 6'd2;
    localparam logic [5:0] TK_BSL       = 6'd3;
    localparam logic [5:0] TK_DOT       = 6'd4;
    localparam logic [5:0] TK_LB        = 6'd25;
    localparam logic [5:0] TK_LBRB      = 6'd26;
    localparam logic [5:0] TK_LBRB_AS   = 6'd27;
    localparam logic [5:0] TK_RB        = 6'd28;
    localparam logic [5:0] TK_LC        = 6'd29;
    localparam logic [5:0] TK_RC        = 6'd30;
    localparam logic [5:0] TK_LP        = 6'd31;
    localparam logic [5:0] TK_RP        = 6'd32;
    localparam logic [5:0] TK_VBAR      = 6'd33;
    localparam logic [5:0] TK_QUESTION  = 6'd34;
    localparam logic [5:0] TK_COLON     = 6'd35;
    localparam logic [5:0] TK_SEMICOLON = 6'd36;
    localparam logic [5:0] TK_COMMA     = 6'd37;
    localparam logic [5:0] TK_INT       = 6'd38;
    localparam logic [5:0] TK_SCHAR     = 6'd39;
    localparam logic [5:0] TK_SLIT      = 6'd40;
    localparam logic [5:0] TK_TRUE      = 6'd41;
    localparam logic [5:0] TK_IDCHAR    = 6'd43;
    localparam logic [5:0] TK_IDENT     = 6'd44;
    localparam logic [5:0] TK_CALLID    = 6'd45;
    localparam logic [5:0] TK_KW0       = 6'd46;

    localparam int          KW_COUNT = 14;
    localparam logic [3:0]  KW_DEF   = 4'd10;
    localparam logic [3:0]  KW_TRUE  = 4'd12;
    localparam logic [62:0] VAL_MAX  = {63{1'b1}};

    // lexer modes, one-hot
    typedef enum logic [3:0] {
        MODE_BEG   = 4'b0001,
        MODE_FNAME = 4'b0010,
        MODE_DOT   = 4'b0100,
        MODE_END   = 4'b1000
    } mode_t;

    // scan phases, one-hot
    typedef enum logic [17:0] {
        PH_IDLE    = 18'd1 << 0,
        PH_COMMENT = 18'd1 << 1,
        PH_BS      = 18'd1 << 2,
        PH_BS_CR   = 18'd1 << 3,
        PH_OP      = 18'd1 << 4,
        PH_LB1     = 18'd1 << 5,
        PH_LB2     = 18'd1 << 6,
        PH_ZERO    = 18'd1 << 7,
        PH_HEX0    = 18'd1 << 8,
        PH_HEX     = 18'd1 << 9,
        PH_DEC     = 18'd1 << 10,
        PH_PREFIX  = 18'd1 << 11,
        PH_IDENT   = 18'd1 << 12,
        PH_DQ      = 18'd1 << 13,
        PH_DQ_ESC  = 18'd1 << 14,
        PH_SQ1     = 18'd1 << 15,
        PH_SQ2     = 18'd1 << 16,
        PH_TQ      = 18'd1 << 17
    } phase_t;

    // keyword lengths
    function automatic logic [5:0] kw_len(input logic [3:0] k);
        logic [5:0] l;
        case (k)
            4'd0, 4'd6:                          l = 6'd2;
            4'd4, 4'd10:                         l = 6'd3;
            4'd1, 4'd3, 4'd12:                   l = 6'd4;
            4'd8:                                l = 6'd6;
            default:                             l = 6'd5;
        endcase
        return l;
    endfunction

    // keyword character at a position, zero past the end
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
        logic [47:0] txt;
        logic [5:0]  l;
        logic [7:0]  c;
        l = kw_len(k);
        case (k)
            4'd0:    txt = 48'("if");
            4'd1:    txt = 48'("then");
            4'd2:    txt = 48'("elsif");
            4'd3:    txt = 48'("else");
            4'd4:    txt = 48'("end");
            4'd5:    txt = 48'("while");
            4'd6:    txt = 48'("do");
            4'd7:    txt = 48'("break");
            4'd8:    txt = 48'("return");
            4'd9:    txt = 48'("class");
            4'd10:   txt = 48'("def");
            4'd11:   txt = 48'("yield");
            4'd12:   txt = 48'("true");
            default: txt = 48'("false");
        endcase
        if ({3'd0, p} < l)
            c = txt[(l - 6'd1 - {3'd0, p}) * 8 +: 8];
        else
            c = 8'd0;
        return c;
    endfunction

    // base code of an operator byte
    function automatic logic [5:0] op_base(input logic [7:0] op);
        logic [5:0] r;
        case (op)
            8'h2A:   r = 6'd5;
            8'h2F:   r = 6'd7;
            8'h25:   r = 6'd9;
            8'h2B:   r = 6'd11;
            8'h2D:   r = 6'd13;
            8'h3C:   r = 6'd15;
            8'h3E:   r = 6'd18;
            8'h3D:   r = 6'd21;
            default: r = 6'd23;
        endcase
        return r;
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
               (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
    endfunction

endpackage

### rtl/script_token_scanner.sv
// script_token_scanner: one source byte per transfer, up to three tokens per byte
// output: the tokens of a byte enter the token queue when the byte is taken, behind any tokens already queued
// throughput: one byte per cycle while each byte yields at most one token and the receiver
// does not stall; bytes yielding more are limited by the single token port, one token per cycle
// reset: asynchronous active low; begin mode, idle phase, line count zero,
// token queue empty, not halted
module script_token_scanner
    import sts_pkg::*;
#(
    parameter int LINE_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  logic [7:0]           in_byte,
    input  logic                 at_end,
    output logic                 tok_valid,
    input  logic                 tok_stall,
    output logic [5:0]           token_kind,
    output logic [62:0]          token_value,
    output logic [LINE_BITS-1:0] line_number,
    output logic                 is_last
);

    // scanner state
    mode_t                mode_reg, mode_next;
    phase_t               phase_reg, phase_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [62:0]          acc_reg, acc_next;
    logic [13:0]          mask_reg, mask_next;
    logic [5:0]           len_reg, len_next;
    logic [7:0]           held_reg, held_next;
    logic [1:0]           qrun_reg, qrun_next;
    logic                 halt_reg, halt_next;

    // token queue
    logic [5:0]           q_kind_reg [4];
    logic [62:0]          q_val_reg  [4];
    logic [LINE_BITS-1:0] q_line_reg [4];
    logic                 q_last_reg [4];
    logic [1:0]           wr_reg, rd_reg;
    logic [2:0]           cnt_reg;

    // results of the current byte
    logic [5:0]           rk [3];
    logic [62:0]          rv [3];
    logic [LINE_BITS-1:0] rl [3];
    logic [1:0]           n;

    logic                 take_in, take_out, eoi;
    logic [7:0]           b, esc;
    logic                 do_start;
    logic [13:0]          clr_cur, clr_zero;
    logic                 hit_found;
    logic [3:0]           hit;
    logic                 hex_ok;
    logic [3:0]           hex_d;
    logic [66:0]          a67, t16, t10;
    logic [62:0]          acc16, acc10;

    assign take_in  = src_valid && !src_stall;
    assign take_out = tok_valid && !tok_stall;
    assign src_stall = cnt_reg > 3'd1;
    assign tok_valid = cnt_reg != 3'd0;

    assign b   = in_byte;
    assign eoi = at_end || b == 8'h00 || b == 8'h04 || b == 8'h1A || b == 8'hFF;

    // keyword mask updates and keyword hit
    always_comb
    begin
        hit_found = 1'b0;
        hit       = 4'd0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            clr_cur[k]  = (len_reg >= kw_len(4'(k))) || (kw_char(4'(k), len_reg[2:0]) != b);
            clr_zero[k] = kw_char(4'(k), 3'd0) != b;
            if (mask_reg[k] && kw_len(4'(k)) == len_reg)
            begin
                hit_found = 1'b1;
                hit       = 4'(k);
            end
        end
    end

    // hex digit decode
    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
            hex_d = 4'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66)
            hex_d = 4'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46)
            hex_d = 4'(b - 8'h37);
        else
            hex_ok = 1'b0;
    end

    // saturating accumulate
    assign a67   = {4'd0, acc_reg};
    assign t16   = (a67 << 4) + {63'd0, hex_d};
    assign t10   = (a67 << 3) + (a67 << 1) + {63'd0, 4'(b - 8'h30)};
    assign acc16 = (t16 > {4'd0, VAL_MAX}) ? VAL_MAX : t16[62:0];
    assign acc10 = (t10 > {4'd0, VAL_MAX}) ? VAL_MAX : t10[62:0];

    // escape mapping
    always_comb
    begin
        case (b)
            8'h62:   esc = 8'h08;
            8'h74:   esc = 8'h09;
            8'h6E:   esc = 8'h0A;
            8'h76:   esc = 8'h0B;
            8'h66:   esc = 8'h0C;
            8'h72:   esc = 8'h0D;
            default: esc = b;
        endcase
    end

    // one step of the scanner
    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        line_next  = line_reg;
        acc_next   = acc_reg;
        mask_next  = mask_reg;
        len_next   = len_reg;
        held_next  = held_reg;
        qrun_next  = qrun_reg;
        halt_next  = halt_reg;
        n          = 2'd0;
        do_start   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rk[i] = TK_END;
            rv[i] = '0;
            rl[i] = line_reg;
        end

        if (!halt_reg)
        begin
            if (eoi)
            begin
                // end of input: close pending token then END, or ERROR and halt if it cannot be closed
                unique case (phase_reg)
                    PH_OP:
                    begin
                        rk[n] = op_base(held_reg); rl[n] = line_next; n = n + 2'd1;
                        mode_next = MODE_BEG;
                    end
                    PH_LB1:
                    begin
                        rk[n] = TK_LB; rl[n] = line_next; n = n + 2'd1;
                        mode_next = MODE_BEG;
                    end
                    PH_LB2:
                    begin
                        rk[n] = TK_LBRB; rl[n] = line_next; n = n + 2'd1;
                        mode_next = MODE_END;
                    end
                    PH_ZERO:
                    begin
                        rk[n] = TK_INT; rl[n] = line_next; n = n + 2'd1;
                    end
                    PH_HEX, PH_DEC:
                    begin
                        rk[n] = TK_INT; rv[n] = acc_reg; rl[n] = line_next; n = n + 2'd1;
                    end
                    PH_IDENT:
                    begin
                        if (!hit_found)
                        begin
                            rk[n] = TK_IDENT; mode_next = MODE_END;
                        end
                        else if (hit >= KW_TRUE)
                        begin
                            rk[n] = TK_TRUE + {2'd0, hit - KW_TRUE}; mode_next = MODE_END;
                        end
                        else if (mode_next == MODE_DOT)
                        begin
                            rk[n] = TK_IDENT; mode_next = MODE_END;
                        end
                        else
                        begin
                            rk[n] = TK_KW0 + {2'd0, hit};
                            mode_next = (hit == KW_DEF) ? MODE_FNAME : MODE_END;
                        end
                        rl[n] = line_next; n = n + 2'd1;
                    end
                    PH_BS, PH_BS_CR:
                    begin
                        rk[n] = TK_BSL; rl[n] = line_next; n = n + 2'd1;
                    end
                    PH_IDLE, PH_COMMENT:
                    begin
                    end
                    default:
                    begin
                        halt_next = 1'b1;
                    end
                endcase
                if (halt_next)
                begin
                    rk[n] = TK_ERROR; rl[n] = line_next; n = n + 2'd1;
                end
                else
                begin
                    rk[n] = TK_END; rl[n] = line_next; n = n + 2'd1;
                    qrun_next = 2'd0;
                end
                phase_next = PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_COMMENT:
                    begin
                        if (b == 8'h0A)
                            do_start = 1'b1;
                    end
                    PH_BS, PH_BS_CR:
                    begin
                        if (b == 8'h0A)
                        begin
                            line_next  = line_next + LINE_BITS'(1);
                            phase_next = PH_IDLE;
                        end
                        else if (b == 8'h0D && phase_reg == PH_BS)
                            phase_next = PH_BS_CR;
                        else
                        begin
                            rk[n] = TK_BSL; rl[n] = line_next; n = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    PH_OP:
                    begin
                        mode_next  = MODE_BEG;
                        phase_next = PH_IDLE;
                        if (b == 8'h3D)
                            rk[n] = op_base(held_reg) + 6'd1;
                        else if ((held_reg == 8'h3C || held_reg == 8'h3E) && b == held_reg)
                            rk[n] = op_base(held_reg) + 6'd2;
                        else
                        begin
                            rk[n] = op_base(held_reg);
                            do_start = 1'b1;
                        end
                        rl[n] = line_next; n = n + 2'd1;
                    end
                    PH_LB1:
                    begin
                        if (b == 8'h5D)
                            phase_next = PH_LB2;
                        else
                        begin
                            rk[n] = TK_LB; rl[n] = line_next; n = n + 2'd1;
                            mode_next = MODE_BEG;
                            do_start  = 1'b1;
                        end
                    end
                    PH_LB2:
                    begin
                        mode_next  = MODE_END;
                        phase_next = PH_IDLE;
                        if (b == 8'h3D)
                            rk[n] = TK_LBRB_AS;
                        else
                        begin
                            rk[n] = TK_LBRB;
                            do_start = 1'b1;
                        end
                        rl[n] = line_next; n = n + 2'd1;
                    end
                    PH_ZERO:
                    begin
                        if (b == 8'h78)
                        begin
                            acc_next   = '0;
                            phase_next = PH_HEX0;
                        end
                        else
                        begin
                            rk[n] = TK_INT; rl[n] = line_next; n = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    PH_HEX0, PH_HEX:
                    begin
                        if (hex_ok)
                        begin
                            acc_next   = acc16;
                            phase_next = PH_HEX;
                        end
                        else if (phase_reg == PH_HEX0)
                        begin
                            rk[n] = TK_ERROR; rl[n] = line_next; n = n + 2'd1;
                            halt_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            rk[n] = TK_INT; rv[n] = acc_reg; rl[n] = line_next; n = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    PH_DEC:
                    begin
                        if (b >= 8'h30 && b <= 8'h39)
                            acc_next = acc10;
                        else
                        begin
                            rk[n] = TK_INT; rv[n] = acc_reg; rl[n] = line_next; n = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    PH_PREFIX:
                    begin
                        if (is_ident_char(b))
                        begin
                            mask_next = mask_reg & ~clr_cur;
                            len_next  = (len_reg < 6'd63) ? len_reg + 6'd1 : len_reg;
                            rk[n] = TK_IDCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                            n = n + 2'd1;
                            phase_next = PH_IDENT;
                        end
                        else
                        begin
                            rk[n] = TK_ERROR; rl[n] = line_next; n = n + 2'd1;
                            halt_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_IDENT:
                    begin
                        if (is_ident_char(b))
                        begin
                            mask_next = mask_reg & ~clr_cur;
                            len_next  = (len_reg < 6'd63) ? len_reg + 6'd1 : len_reg;
                            rk[n] = TK_IDCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                            n = n + 2'd1;
                        end
                        else if (b == 8'h21 || b == 8'h3F)
                        begin
                            rk[n] = TK_IDCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                            n = n + 2'd1;
                            rk[n] = TK_CALLID; rl[n] = line_next; n = n + 2'd1;
                            mode_next  = MODE_END;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // close the identifier, keyword or literal
                            if (!hit_found)
                            begin
                                rk[n] = TK_IDENT; mode_next = MODE_END;
                            end
                            else if (hit >= KW_TRUE)
                            begin
                                rk[n] = TK_TRUE + {2'd0, hit - KW_TRUE}; mode_next = MODE_END;
                            end
                            else if (mode_reg == MODE_DOT)
                            begin
                                rk[n] = TK_IDENT; mode_next = MODE_END;
                            end
                            else
                            begin
                                rk[n] = TK_KW0 + {2'd0, hit};
                                mode_next = (hit == KW_DEF) ? MODE_FNAME : MODE_END;
                            end
                            rl[n] = line_next; n = n + 2'd1;
                            do_start = 1'b1;
                        end
                    end
                    PH_DQ:
                    begin
                        if (b == 8'h5C)
                            phase_next = PH_DQ_ESC;
                        else if (b == 8'h22)
                        begin
                            rk[n] = TK_SLIT; rl[n] = line_next; n = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            rk[n] = TK_SCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                            n = n + 2'd1;
                        end
                    end
                    PH_DQ_ESC:
                    begin
                        rk[n] = TK_SCHAR; rv[n] = {55'd0, esc}; rl[n] = line_next;
                        n = n + 2'd1;
                        phase_next = PH_DQ;
                    end
                    PH_SQ1, PH_SQ2:
                    begin
                        if (b != 8'h27)
                        begin
                            rk[n] = TK_ERROR; rl[n] = line_next; n = n + 2'd1;
                            halt_next  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if (phase_reg == PH_SQ1)
                            phase_next = PH_SQ2;
                        else
                        begin
                            phase_next = PH_TQ;
                            qrun_next  = 2'd0;
                        end
                    end
                    PH_TQ:
                    begin
                        if (b == 8'h27)
                        begin
                            if (qrun_reg >= 2'd2)
                            begin
                                rk[n] = TK_SLIT; rl[n] = line_next; n = n + 2'd1;
                                qrun_next  = 2'd0;
                                phase_next = PH_IDLE;
                            end
                            else
                                qrun_next = qrun_reg + 2'd1;
                        end
                        else
                        begin
                            // flush held quotes, then the byte
                            if (qrun_reg >= 2'd1)
                            begin
                                rk[n] = TK_SCHAR; rv[n] = 63'h27; rl[n] = line_next;
                                n = n + 2'd1;
                            end
                            if (qrun_reg >= 2'd2)
                            begin
                                rk[n] = TK_SCHAR; rv[n] = 63'h27; rl[n] = line_next;
                                n = n + 2'd1;
                            end
                            qrun_next = 2'd0;
                            if (b == 8'h0A)
                                line_next = line_next + LINE_BITS'(1);
                            rk[n] = TK_SCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                            n = n + 2'd1;
                        end
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                // scan the byte as the start of a token
                if (do_start)
                begin
                    phase_next = PH_IDLE;
                    case (b) inside
                        8'h20, 8'h09, 8'h0C, 8'h0D, 8'h0B:
                        begin
                        end
                        8'h23: phase_next = PH_COMMENT;
                        8'h0A:
                        begin
                            line_next = line_next + LINE_BITS'(1);
                            if (mode_next == MODE_END)
                            begin
                                rk[n] = TK_LF; rl[n] = line_next; n = n + 2'd1;
                                mode_next = MODE_BEG;
                            end
                        end
                        8'h5C: phase_next = PH_BS;
                        8'h22:
                        begin
                            mode_next = MODE_END; phase_next = PH_DQ;
                        end
                        8'h27:
                        begin
                            mode_next = MODE_END; phase_next = PH_SQ1;
                        end
                        8'h2E:
                        begin
                            rk[n] = TK_DOT; rl[n] = line_next; n = n + 2'd1;
                            mode_next = MODE_DOT;
                        end
                        8'h2A, 8'h2F, 8'h25, 8'h2B, 8'h2D, 8'h3C, 8'h3E, 8'h3D, 8'h21:
                        begin
                            held_next = b; phase_next = PH_OP;
                        end
                        8'h5B:
                        begin
                            if (mode_next == MODE_FNAME || mode_next == MODE_DOT)
                                phase_next = PH_LB1;
                            else
                            begin
                                rk[n] = TK_LB; rl[n] = line_next; n = n + 2'd1;
                                mode_next = MODE_BEG;
                            end
                        end
                        8'h7B, 8'h7C, 8'h28, 8'h3F, 8'h3A, 8'h3B, 8'h2C:
                        begin
                            case (b)
                                8'h7B:   rk[n] = TK_LC;
                                8'h7C:   rk[n] = TK_VBAR;
                                8'h28:   rk[n] = TK_LP;
                                8'h3F:   rk[n] = TK_QUESTION;
                                8'h3A:   rk[n] = TK_COLON;
                                8'h3B:   rk[n] = TK_SEMICOLON;
                                default: rk[n] = TK_COMMA;
                            endcase
                            rl[n] = line_next; n = n + 2'd1;
                            mode_next = MODE_BEG;
                        end
                        8'h5D, 8'h7D, 8'h29:
                        begin
                            case (b)
                                8'h5D:   rk[n] = TK_RB;
                                8'h7D:   rk[n] = TK_RC;
                                default: rk[n] = TK_RP;
                            endcase
                            rl[n] = line_next; n = n + 2'd1;
                            mode_next = MODE_END;
                        end
                        8'h30:
                        begin
                            mode_next = MODE_END; phase_next = PH_ZERO;
                        end
                        8'h40, 8'h24:
                        begin
                            rk[n] = TK_IDCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                            n = n + 2'd1;
                            mask_next  = '0;
                            len_next   = '0;
                            phase_next = PH_PREFIX;
                        end
                        [8'h31:8'h39]:
                        begin
                            mode_next  = MODE_END;
                            acc_next   = {59'd0, 4'(b - 8'h30)};
                            phase_next = PH_DEC;
                        end
                        default:
                        begin
                            if (is_ident_char(b))
                            begin
                                mask_next = ~clr_zero;
                                len_next  = 6'd1;
                                rk[n] = TK_IDCHAR; rv[n] = {55'd0, b}; rl[n] = line_next;
                                n = n + 2'd1;
                                phase_next = PH_IDENT;
                            end
                            else
                            begin
                                rk[n] = TK_ERROR; rl[n] = line_next; n = n + 2'd1;
                                halt_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BEG;
            phase_reg <= PH_IDLE;
            line_reg  <= '0;
            acc_reg   <= '0;
            mask_reg  <= '1;
            len_reg   <= '0;
            held_reg  <= '0;
            qrun_reg  <= '0;
            halt_reg  <= 1'b0;
        end
        else if (take_in)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            line_reg  <= line_next;
            acc_reg   <= acc_next;
            mask_reg  <= mask_next;
            len_reg   <= len_next;
            held_reg  <= held_next;
            qrun_reg  <= qrun_next;
            halt_reg  <= halt_next;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (take_in)
                wr_reg <= wr_reg + n;
            if (take_out)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + (take_in ? {1'b0, n} : 3'd0) - (take_out ? 3'd1 : 3'd0);
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < n)
                begin
                    q_kind_reg[wr_reg + 2'(i)] <= rk[i];
                    q_val_reg[wr_reg + 2'(i)]  <= rv[i];
                    q_line_reg[wr_reg + 2'(i)] <= rl[i];
                    q_last_reg[wr_reg + 2'(i)] <= (2'(i) == n - 2'd1);
                end
            end
        end
    end

    assign token_kind  = q_kind_reg[rd_reg];
    assign token_value = q_val_reg[rd_reg];
    assign line_number = q_line_reg[rd_reg];
    assign is_last     = q_last_reg[rd_reg];

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import sts_pkg::*;

    // operator base codes, the '=' form is base + 1, the doubled form base + 2
    localparam logic [5:0] TK_MUL    = 6'd5;
    localparam logic [5:0] TK_DIV    = 6'd7;
    localparam logic [5:0] TK_MOD    = 6'd9;
    localparam logic [5:0] TK_ADD    = 6'd11;
    localparam logic [5:0] TK_SUB    = 6'd13;
    localparam logic [5:0] TK_LT     = 6'd15;
    localparam logic [5:0] TK_GT     = 6'd18;
    localparam logic [5:0] TK_ASSIGN = 6'd21;
    localparam logic [5:0] TK_BANG   = 6'd23;
    localparam int         MAX_TOK   = 3;
    localparam int         LIMIT     = 400000;

    localparam string KW_WORDS [14] = '{"if", "then", "elsif", "else", "end", "while",
        "do", "break", "return", "class", "def", "yield", "true", "false"};

    typedef struct {
        logic [5:0]  kind;
        logic [62:0] value;
        logic [31:0] line;
        logic        last;
    } token_t;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [7:0]  in_byte;
    logic        at_end;
    logic        tok_valid;
    logic        tok_stall;
    logic [5:0]  token_kind;
    logic [62:0] token_value;
    logic [31:0] line_number;
    logic        is_last;

    // token expectations worked out from the accepted byte stream
    class token_scoreboard;
        token_t      pending_tokens[$];
        mode_t       mode;
        phase_t      phase;
        logic [31:0] lines;
        logic [63:0] accum;
        string       word;
        bit          prefixed;
        logic [7:0]  held;
        int          quotes;
        bit          halted;
        int          step_count;
        int          errors;

        function new();
            mode = MODE_BEG;
            phase = PH_IDLE;
            lines = '0;
            accum = '0;
            word = "";
            prefixed = 0;
            held = '0;
            quotes = 0;
            halted = 0;
            errors = 0;
        endfunction

        function void put(logic [5:0] k, logic [62:0] v);
            token_t t;
            if (step_count < MAX_TOK)
            begin
                t.kind = k;
                t.value = v;
                t.line = lines;
                t.last = 0;
                pending_tokens.push_back(t);
                step_count++;
            end
        endfunction

        function void fail();
            put(TK_ERROR, '0);
            halted = 1;
            phase = PH_IDLE;
        endfunction

        function bit word_char(logic [7:0] b);
            return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
                   (b >= "A" && b <= "Z") || b == "_";
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= "0" && b <= "9") return b - "0";
            if (b >= "a" && b <= "f") return b - "a" + 10;
            if (b >= "A" && b <= "F") return b - "A" + 10;
            return -1;
        endfunction

        function logic [5:0] op_code(logic [7:0] b);
            case (b)
                "*":     return TK_MUL;
                "/":     return TK_DIV;
                "%":     return TK_MOD;
                "+":     return TK_ADD;
                "-":     return TK_SUB;
                "<":     return TK_LT;
                ">":     return TK_GT;
                "=":     return TK_ASSIGN;
                default: return TK_BANG;
            endcase
        endfunction

        // saturating accumulate at 2^63-1
        function void accumulate(int base, int d);
            if (accum > (64'(VAL_MAX) - 64'(d)) / 64'(base))
                accum = 64'(VAL_MAX);
            else
                accum = accum * base + d;
        endfunction

        // keywords never exceed six characters, so longer words are cut short
        function void word_add(logic [7:0] b);
            if (word.len() < 7)
                word = $sformatf("%s%c", word, b);
            put(TK_IDCHAR, 63'(b));
        endfunction

        function void word_close();
            int hit;
            hit = -1;
            if (!prefixed)
                for (int k = 0; k < 14; k++)
                    if (word == KW_WORDS[k]) hit = k;
            if (hit < 0 || (hit < KW_TRUE && mode == MODE_DOT))
            begin
                put(TK_IDENT, '0);
                mode = MODE_END;
            end
            else if (hit >= KW_TRUE)
            begin
                put(TK_TRUE + 6'(hit - KW_TRUE), '0);
                mode = MODE_END;
            end
            else
            begin
                put(TK_KW0 + 6'(hit), '0);
                mode = (hit == KW_DEF) ? MODE_FNAME : MODE_END;
            end
            phase = PH_IDLE;
        endfunction

        function void new_line();
            lines = lines + 1;
        endfunction

        // first byte of a token
        function void begin_token(logic [7:0] b);
            phase = PH_IDLE;
            case (b)
                " ", "\t", 8'h0C, "\r", 8'h0B: ;
                "#": phase = PH_COMMENT;
                "\n":
                begin
                    new_line();
                    if (mode == MODE_END)
                    begin
                        put(TK_LF, '0);
                        mode = MODE_BEG;
                    end
                end
                "\\": phase = PH_BS;
                "\"":
                begin
                    mode = MODE_END;
                    phase = PH_DQ;
                end
                "'":
                begin
                    mode = MODE_END;
                    phase = PH_SQ1;
                end
                ".":
                begin
                    put(TK_DOT, '0);
                    mode = MODE_DOT;
                end
                "*", "/", "%", "+", "-", "<", ">", "=", "!":
                begin
                    held = b;
                    phase = PH_OP;
                end
                "[":
                    if (mode == MODE_FNAME || mode == MODE_DOT)
                        phase = PH_LB1;
                    else
                    begin
                        put(TK_LB, '0);
                        mode = MODE_BEG;
                    end
                "{", "|", "(", "?", ":", ";", ",":
                begin
                    case (b)
                        "{":     put(TK_LC, '0);
                        "|":     put(TK_VBAR, '0);
                        "(":     put(TK_LP, '0);
                        "?":     put(TK_QUESTION, '0);
                        ":":     put(TK_COLON, '0);
                        ";":     put(TK_SEMICOLON, '0);
                        default: put(TK_COMMA, '0);
                    endcase
                    mode = MODE_BEG;
                end
                "]", "}", ")":
                begin
                    put(b == "]" ? TK_RB : (b == "}" ? TK_RC : TK_RP), '0);
                    mode = MODE_END;
                end
                "0":
                begin
                    mode = MODE_END;
                    phase = PH_ZERO;
                end
                "@", "$":
                begin
                    put(TK_IDCHAR, 63'(b));
                    word = "";
                    prefixed = 1;
                    phase = PH_PREFIX;
                end
                default:
                    if (b >= "1" && b <= "9")
                    begin
                        mode = MODE_END;
                        accum = 64'(b - "0");
                        phase = PH_DEC;
                    end
                    else if (word_char(b))
                    begin
                        word = "";
                        prefixed = 0;
                        word_add(b);
                        phase = PH_IDENT;
                    end
                    else
                        fail();
            endcase
        endfunction

        function void scan(logic [7:0] b);
            int d;
            logic [7:0] c;
            case (phase)
                PH_COMMENT:
                    if (b == "\n") begin_token(b);
                PH_BS, PH_BS_CR:
                    if (b == "\n")
                    begin
                        new_line();
                        phase = PH_IDLE;
                    end
                    else if (b == "\r" && phase == PH_BS)
                        phase = PH_BS_CR;
                    else
                    begin
                        put(TK_BSL, '0);
                        begin_token(b);
                    end
                PH_OP:
                begin
                    mode = MODE_BEG;
                    phase = PH_IDLE;
                    if (b == "=")
                        put(op_code(held) + 6'd1, '0);
                    else if ((held == "<" || held == ">") && b == held)
                        put(op_code(held) + 6'd2, '0);
                    else
                    begin
                        put(op_code(held), '0);
                        begin_token(b);
                    end
                end
                PH_LB1:
                    if (b == "]")
                        phase = PH_LB2;
                    else
                    begin
                        put(TK_LB, '0);
                        mode = MODE_BEG;
                        begin_token(b);
                    end
                PH_LB2:
                begin
                    mode = MODE_END;
                    phase = PH_IDLE;
                    if (b == "=")
                        put(TK_LBRB_AS, '0);
                    else
                    begin
                        put(TK_LBRB, '0);
                        begin_token(b);
                    end
                end
                PH_ZERO:
                    if (b == "x")
                    begin
                        accum = '0;
                        phase = PH_HEX0;
                    end
                    else
                    begin
                        put(TK_INT, '0);
                        begin_token(b);
                    end
                PH_HEX0, PH_HEX:
                begin
                    d = hex_digit(b);
                    if (d >= 0)
                    begin
                        accumulate(16, d);
                        phase = PH_HEX;
                    end
                    else if (phase == PH_HEX0)
                        fail();
                    else
                    begin
                        put(TK_INT, accum[62:0]);
                        begin_token(b);
                    end
                end
                PH_DEC:
                    if (b >= "0" && b <= "9")
                        accumulate(10, b - "0");
                    else
                    begin
                        put(TK_INT, accum[62:0]);
                        begin_token(b);
                    end
                PH_PREFIX:
                    if (word_char(b))
                    begin
                        word_add(b);
                        phase = PH_IDENT;
                    end
                    else
                        fail();
                PH_IDENT:
                    if (word_char(b))
                        word_add(b);
                    else if (b == "!" || b == "?")
                    begin
                        put(TK_IDCHAR, 63'(b));
                        put(TK_CALLID, '0);
                        mode = MODE_END;
                        phase = PH_IDLE;
                    end
                    else
                    begin
                        word_close();
                        begin_token(b);
                    end
                PH_DQ:
                    if (b == "\\")
                        phase = PH_DQ_ESC;
                    else if (b == "\"")
                    begin
                        put(TK_SLIT, '0);
                        phase = PH_IDLE;
                    end
                    else
                        put(TK_SCHAR, 63'(b));
                PH_DQ_ESC:
                begin
                    case (b)
                        "b":     c = 8'h08;
                        "t":     c = 8'h09;
                        "n":     c = 8'h0A;
                        "v":     c = 8'h0B;
                        "f":     c = 8'h0C;
                        "r":     c = 8'h0D;
                        default: c = b;
                    endcase
                    put(TK_SCHAR, 63'(c));
                    phase = PH_DQ;
                end
                PH_SQ1, PH_SQ2:
                    if (b != "'")
                        fail();
                    else if (phase == PH_SQ1)
                        phase = PH_SQ2;
                    else
                    begin
                        phase = PH_TQ;
                        quotes = 0;
                    end
                PH_TQ:
                    if (b == "'")
                    begin
                        if (quotes >= 2)
                        begin
                            put(TK_SLIT, '0);
                            quotes = 0;
                            phase = PH_IDLE;
                        end
                        else
                            quotes++;
                    end
                    else
                    begin
                        while (quotes > 0)
                        begin
                            put(TK_SCHAR, 63'("'"));
                            quotes--;
                        end
                        if (b == "\n") new_line();
                        put(TK_SCHAR, 63'(b));
                    end
                default:
                    begin_token(b);
            endcase
        endfunction

        // end of input: close what is pending, then END, or fail if it cannot be closed
        function void close_input();
            case (phase)
                PH_OP:
                begin
                    put(op_code(held), '0);
                    mode = MODE_BEG;
                end
                PH_LB1:
                begin
                    put(TK_LB, '0);
                    mode = MODE_BEG;
                end
                PH_LB2:
                begin
                    put(TK_LBRB, '0);
                    mode = MODE_END;
                end
                PH_ZERO:          put(TK_INT, '0);
                PH_HEX, PH_DEC:   put(TK_INT, accum[62:0]);
                PH_IDENT:         word_close();
                PH_BS, PH_BS_CR:  put(TK_BSL, '0);
                PH_IDLE, PH_COMMENT: ;
                default:
                begin
                    fail();
                    return;
                end
            endcase
            put(TK_END, '0);
            phase = PH_IDLE;
            quotes = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic e);
            if (halted) return;
            step_count = 0;
            if (e || b == 8'h00 || b == 8'h04 || b == 8'h1A || b == 8'hFF)
                close_input();
            else
                scan(b);
            if (step_count > 0)
                pending_tokens[$].last = 1;
        endfunction

        function void check_token(logic [5:0] k, logic [62:0] v, logic [31:0] l, logic z);
            token_t t;
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d value %0d", k, v);
                errors++;
                return;
            end
            t = pending_tokens.pop_front();
            if (k !== t.kind)
            begin
                $error("token_kind: expected %0d, got %0d", t.kind, k);
                errors++;
            end
            if (v !== t.value)
            begin
                $error("token_value: expected %0d, got %0d", t.value, v);
                errors++;
            end
            if (l !== t.line)
            begin
                $error("line_number: expected %0d, got %0d", t.line, l);
                errors++;
            end
            if (z !== t.last)
            begin
                $error("is_last: expected %0d, got %0d", t.last, z);
                errors++;
            end
        endfunction
    endclass

    token_scoreboard sb;
    int              cycles;
    int              burst_left;
    int              bytes_sent;
    int              stall_style;
    int              stall_count;

    script_token_scanner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .in_byte     (in_byte),
        .at_end      (at_end),
        .tok_valid   (tok_valid),
        .tok_stall   (tok_stall),
        .token_kind  (token_kind),
        .token_value (token_value),
        .line_number (line_number),
        .is_last     (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // receiver stall pattern, switching style now and then
    always @(negedge clk)
    begin
        stall_count++;
        if (stall_count % 150 == 0)
            stall_style = $urandom_range(0, 2);
        case (stall_style)
            0:       tok_stall <= 1'b0;
            1:       tok_stall <= ($urandom_range(0, 3) == 0);
            default: tok_stall <= (stall_count % 16) < 10;
        endcase
    end

    // token transfers
    always @(posedge clk)
        if (rst_n && tok_valid && !tok_stall)
            sb.check_token(token_kind, token_value, line_number, is_last);

    // one byte transfer, with bursts and gaps on the source side
    task automatic send_byte(input logic [7:0] b, input logic e);
        if (burst_left == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_byte <= b;
        at_end <= e;
        src_valid <= 1'b1;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        sb.note_byte(b, e);
        burst_left--;
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_word();
        int n;
        if ($urandom_range(0, 2) == 0)
            send_text(KW_WORDS[$urandom_range(0, 13)]);
        else
        begin
            n = $urandom_range(1, 7);
            send_byte(8'("a" + $urandom_range(0, 25)), 1'b0);
            for (int i = 1; i < n; i++)
                case ($urandom_range(0, 3))
                    0:       send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
                    1:       send_byte("_", 1'b0);
                    2:       send_byte(8'("A" + $urandom_range(0, 25)), 1'b0);
                    default: send_byte(8'("a" + $urandom_range(0, 25)), 1'b0);
                endcase
        end
    endtask

    // string content byte that is neither an end byte nor the given delimiter
    function automatic logic [7:0] text_byte(input logic [7:0] delim);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 254));
        while (b == 8'h04 || b == 8'h1A || b == delim || b == "\\");
        return b;
    endfunction

    // one well-formed token, or a run of layout
    task automatic send_token();
        string ops;
        string marks;
        logic [7:0] ends [4];
        ops = "*/%+-<>=!";
        marks = "{}()|?:;,]";
        ends = '{8'h00, 8'h04, 8'h1A, 8'hFF};
        case ($urandom_range(0, 15))
            0, 1, 2:
            begin
                if ($urandom_range(0, 5) == 0)
                    send_byte($urandom_range(0, 1) ? "@" : "$", 1'b0);
                send_word();
                if ($urandom_range(0, 5) == 0)
                    send_byte($urandom_range(0, 1) ? "!" : "?", 1'b0);
            end
            3:
            begin
                send_byte(".", 1'b0);
                send_word();
            end
            4:
            begin
                if ($urandom_range(0, 1)) send_text("def ");
                else send_byte(".", 1'b0);
                send_text($urandom_range(0, 1) ? "[]=" : "[]");
            end
            5:
            begin
                send_byte(ops[$urandom_range(0, 8)], 1'b0);
                case ($urandom_range(0, 2))
                    0: send_byte("=", 1'b0);
                    1: send_byte($urandom_range(0, 1) ? "<" : ">", 1'b0);
                    default: ;
                endcase
            end
            6: send_byte(marks[$urandom_range(0, 9)], 1'b0);
            7:
            begin
                case ($urandom_range(0, 4))
                    0: send_text($sformatf("%0d", $urandom_range(1, 99999)));
                    1: send_text("99999999999999999999");
                    2: send_text("0");
                    3: send_text($sformatf("0x%0h", $urandom()));
                    default: send_text("0xFfffffffffffffff1");
                endcase
                send_byte(" ", 1'b0);
            end
            8:
            begin
                send_byte("\"", 1'b0);
                repeat ($urandom_range(0, 6))
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_byte("\\", 1'b0);
                        send_byte(text_byte(8'h04), 1'b0);
                    end
                    else
                        send_byte(text_byte("\""), 1'b0);
                send_byte("\"", 1'b0);
            end
            9:
            begin
                send_text("'''");
                repeat ($urandom_range(0, 5))
                begin
                    repeat ($urandom_range(0, 2)) send_byte("'", 1'b0);
                    send_byte($urandom_range(0, 2) ? text_byte("'") : "\n", 1'b0);
                end
                send_text("'''");
            end
            10:
            begin
                send_byte("#", 1'b0);
                repeat ($urandom_range(0, 5)) send_byte(text_byte("\n"), 1'b0);
                send_byte("\n", 1'b0);
            end
            11:
                case ($urandom_range(0, 2))
                    0: send_text("\\\n");
                    1: send_text("\\\r\n");
                    default: send_text("\\ ");
                endcase
            12: send_byte("\n", 1'b0);
            13:
                if ($urandom_range(0, 1))
                    send_byte(8'($urandom()), 1'b1);
                else
                    send_byte(ends[$urandom_range(0, 3)], 1'b0);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: ;
            1: send_byte("\t", 1'b0);
            default: send_byte(" ", 1'b0);
        endcase
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        src_valid = 1'b0;
        in_byte = 8'h00;
        at_end = 1'b0;
        tok_stall = 1'b0;
        burst_left = 0;
        stall_style = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: keyword modes, brackets after a name, shift-assign, the largest hex value
        send_text("def x[]=.if[]<<=");
        send_byte(8'hFF, 1'b0);
        send_text("0x7fffffffffffffff a!\n");
        send_byte(8'h00, 1'b1);

        while (bytes_sent < 350)
            send_token();

        // a single failure ends the scan, later bytes are ignored
        case ($urandom_range(0, 5))
            0: send_byte(8'($urandom_range(8'h80, 8'hFE)), 1'b0);
            1: send_byte("~", 1'b0);
            2: send_text("'a");
            3: send_text("0xg");
            4: send_text("@ ");
            default:
            begin
                send_text("\"ab");
                send_byte(8'h00, 1'b1);
            end
        endcase
        send_text("x 1 ");
        src_valid <= 1'b0;

        while (sb.pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_tokens.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
